// ===== hdl/sgr_pkg.sv =====
package sgr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int GAP_DOTS_DEF   = 1;

	localparam int CODE_BITS   = 8;
	localparam int SCALE_BITS  = 6;
	localparam int FONT_COLS   = 5;
	localparam int FONT_ROWS   = 7;
	localparam int GLYPH_DOTS  = FONT_COLS * FONT_ROWS;
	localparam int GLYPH_BITS  = 6;
	localparam int ROW_BITS    = 3;
	localparam int APB_DATA    = 32;
	localparam int APB_ADDR    = 4;
	localparam int REG_SEL_LSB = 2;

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1);

	// Register indexes, at byte address 4 * index.
	localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
	localparam logic [1:0] REG_GLYPH_SCALE = 2'd2;

	localparam logic [CODE_BITS-1:0] CHR_DIGIT_0 = 8'h30;
	localparam logic [CODE_BITS-1:0] CHR_DIGIT_9 = 8'h39;
	localparam logic [CODE_BITS-1:0] CHR_UPPER_A = 8'h41;
	localparam logic [CODE_BITS-1:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [CODE_BITS-1:0] CHR_LOWER_A = 8'h61;
	localparam logic [CODE_BITS-1:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [GLYPH_BITS-1:0] LETTER_BASE = 6'd10;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} sgr_state_t;

	typedef struct packed {
		logic                  hit;
		logic [GLYPH_BITS-1:0] idx;
	} sgr_glyph_sel_t;

	// Maps a character byte to its font entry; lower case folds onto upper case.
	function automatic sgr_glyph_sel_t glyph_select(input logic [CODE_BITS-1:0] code);
		sgr_glyph_sel_t sel;
		logic [CODE_BITS-1:0] diff;
		sel  = '0;
		diff = '0;
		if (code >= CHR_DIGIT_0 && code <= CHR_DIGIT_9) begin
			diff    = code - CHR_DIGIT_0;
			sel.hit = 1'b1;
			sel.idx = diff[GLYPH_BITS-1:0];
		end else if (code >= CHR_UPPER_A && code <= CHR_UPPER_Z) begin
			diff    = code - CHR_UPPER_A;
			sel.hit = 1'b1;
			sel.idx = diff[GLYPH_BITS-1:0] + LETTER_BASE;
		end else if (code >= CHR_LOWER_A && code <= CHR_LOWER_Z) begin
			diff    = code - CHR_LOWER_A;
			sel.hit = 1'b1;
			sel.idx = diff[GLYPH_BITS-1:0] + LETTER_BASE;
		end
		return sel;
	endfunction

	// Font contents: bit (col * 7 + row) is the dot at that column and row,
	// so the word reads in scan order from bit 0 upward.
	function automatic logic [GLYPH_DOTS-1:0] font_glyph(input logic [GLYPH_BITS-1:0] idx);
		logic [GLYPH_DOTS-1:0] g;
		unique case (idx)
			6'd0:    g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
			6'd1:    g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
			6'd2:    g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
			6'd3:    g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
			6'd4:    g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
			6'd5:    g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
			6'd6:    g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
			6'd7:    g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
			6'd8:    g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			6'd9:    g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
			6'd10:   g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
			6'd11:   g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7F};
			6'd12:   g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3E};
			6'd13:   g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
			6'd14:   g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
			6'd15:   g = {7'h01, 7'h01, 7'h09, 7'h09, 7'h7F};
			6'd16:   g = {7'h32, 7'h51, 7'h41, 7'h41, 7'h3E};
			6'd17:   g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			6'd18:   g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
			6'd19:   g = {7'h01, 7'h3F, 7'h41, 7'h40, 7'h20};
			6'd20:   g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F};
			6'd21:   g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
			6'd22:   g = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
			6'd23:   g = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
			6'd24:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
			6'd25:   g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
			6'd26:   g = {7'h5E, 7'h21, 7'h51, 7'h41, 7'h3E};
			6'd27:   g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
			6'd28:   g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
			6'd29:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			6'd30:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
			6'd31:   g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
			6'd32:   g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
			6'd33:   g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
			6'd34:   g = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
			6'd35:   g = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== hdl/sgr_char_if.sv =====
interface sgr_char_if;
	logic                           valid;
	logic                           ready;
	logic [sgr_pkg::CODE_BITS-1:0]  char_code;
	logic                           first_of_text;

	modport source (output valid, output char_code, output first_of_text, input ready);
	modport sink   (input valid, input char_code, input first_of_text, output ready);
endinterface

// ===== hdl/sgr_rect_if.sv =====
interface sgr_rect_if #(
	parameter int COORD_BITS = sgr_pkg::COORD_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [COORD_BITS-1:0]    rect_x;
	logic signed [COORD_BITS-1:0]    rect_y;
	logic [sgr_pkg::SCALE_BITS-1:0]  rect_side;
	logic                            last_of_glyph;

	modport source (output valid, output rect_x, output rect_y, output rect_side,
		output last_of_glyph, input ready);
	modport sink   (input valid, input rect_x, input rect_y, input rect_side,
		input last_of_glyph, output ready);
endinterface

// ===== hdl/scaled_glyph_rectangle_generator.sv =====
// Turns text into black square fill commands from a 5x7 dot font.
// char_in takes one character per transaction: char_code, and first_of_text,
// which puts the horizontal cursor back to origin_x before that character.
// Digits and letters (either case) are drawn; every other byte is blank.
// rect_out gives one transaction per set dot of the glyph, in column order and
// top to bottom within a column, with last_of_glyph on the final one.
// When a drawn character is taken, its glyph word comes out of the registered
// font ROM, and then the dots are scanned one per cycle while the output is not
// stalled, up to the last set dot. Each command passes through the output
// register, and the next character is taken only once the scan is done.
// A blank character, or any character while glyph_scale is zero, draws nothing
// and only moves the cursor by (5 + GAP_DOTS) * glyph_scale.
// When the receiver stalls, the output register holds its command and the
// scan waits on the next set dot. Reset clears the cursor and the output,
// and sets origin_x = origin_y = 0 and glyph_scale = 1.
// Registers on the APB port: origin_x at 0x0, origin_y at 0x4, glyph_scale at 0x8.
module scaled_glyph_rectangle_generator #(
	parameter int COORD_BITS = sgr_pkg::COORD_BITS_DEF,
	parameter int GAP_DOTS   = sgr_pkg::GAP_DOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sgr_char_if.sink                       char_in,
	sgr_rect_if.source                     rect_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sgr_pkg::APB_ADDR-1:0]   paddr,
	input  logic [sgr_pkg::APB_DATA-1:0]   pwdata,
	output logic [sgr_pkg::APB_DATA-1:0]   prdata,
	output logic                           pready
);
	import sgr_pkg::*;

	// Two spare bits hold any sum before saturation.
	localparam int W        = COORD_BITS + 2;
	localparam int ADV_DOTS = FONT_COLS + GAP_DOTS;
	localparam logic signed [W-1:0] SAT_HI = {3'b000, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(FONT_ROWS - 1);

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [W-1:0] v);
		logic signed [W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = v;
		end
		return r[COORD_BITS-1:0];
	endfunction

	logic signed [COORD_BITS-1:0] origin_x_q;
	logic signed [COORD_BITS-1:0] origin_y_q;
	logic [SCALE_BITS-1:0]        scale_q;
	logic signed [COORD_BITS-1:0] cursor_q;

	sgr_state_t state_q, state_d;

	logic [GLYPH_DOTS-1:0]  dots_q;
	logic [ROW_BITS-1:0]    row_q;
	logic signed [W-1:0]    x_q;
	logic signed [W-1:0]    y_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] out_x_q;
	logic signed [COORD_BITS-1:0] out_y_q;
	logic [SCALE_BITS-1:0]        out_side_q;
	logic                         out_last_q;

	sgr_glyph_sel_t         sel;
	logic                   in_fire;
	logic                   drawable;
	logic                   cfg_write;
	logic [1:0]             reg_sel;
	logic signed [COORD_BITS-1:0] base_x;
	logic signed [W-1:0]    scale_w;
	logic signed [W-1:0]    adv_w;
	logic                   dot;
	logic                   is_last;
	logic                   out_free;
	logic                   step;
	logic                   emit;

	// ---------------------------------------------------------------- config
	assign pready    = 1'b1;
	assign reg_sel   = paddr[REG_SEL_LSB +: 2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			scale_q    <= SCALE_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_ORIGIN_X:    origin_x_q <= pwdata[COORD_BITS-1:0];
				REG_ORIGIN_Y:    origin_y_q <= pwdata[COORD_BITS-1:0];
				REG_GLYPH_SCALE: scale_q    <= pwdata[SCALE_BITS-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ORIGIN_X:    prdata = APB_DATA'(origin_x_q);
			REG_ORIGIN_Y:    prdata = APB_DATA'(origin_y_q);
			REG_GLYPH_SCALE: prdata = APB_DATA'(scale_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- input
	assign sel      = glyph_select(char_in.char_code);
	assign in_fire  = char_in.valid && char_in.ready;
	assign drawable = sel.hit && (scale_q != '0);
	assign base_x   = char_in.first_of_text ? origin_x_q : cursor_q;
	assign scale_w  = W'(scale_q);
	assign adv_w    = W'(ADV_DOTS * 32'(scale_q));

	// ---------------------------------------------------------------- scan
	// The glyph word shifts right one dot per step; the dot is the last one
	// once nothing is left above it.
	assign dot      = dots_q[0];
	assign is_last  = (dots_q[GLYPH_DOTS-1:1] == '0);
	assign out_free = !out_valid_q || rect_out.ready;
	assign step     = (state_q == ST_SCAN) && (!dot || out_free);
	assign emit     = (state_q == ST_SCAN) && dot && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire && drawable) state_d = ST_SCAN;
			ST_SCAN: if (step && is_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: char_in.ready = 1'b1;
			ST_SCAN: char_in.ready = 1'b0;
			default: char_in.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cursor_q <= sat_coord(W'(base_x) + adv_w);
			end
		end
	end

	// Font ROM with a registered read, plus the running dot coordinates.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dots_q <= font_glyph(sel.idx);
			row_q  <= '0;
			x_q    <= W'(base_x);
			y_q    <= W'(origin_y_q);
		end else if (step) begin
			dots_q <= dots_q >> 1;
			if (row_q == LAST_ROW) begin
				row_q <= '0;
				y_q   <= W'(origin_y_q);
				x_q   <= x_q + scale_w;
			end else begin
				row_q <= row_q + ROW_BITS'(1);
				y_q   <= y_q + scale_w;
			end
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rect_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q    <= sat_coord(x_q);
			out_y_q    <= sat_coord(y_q);
			out_side_q <= scale_q;
			out_last_q <= is_last;
		end
	end

	assign rect_out.valid         = out_valid_q;
	assign rect_out.rect_x        = out_x_q;
	assign rect_out.rect_y        = out_y_q;
	assign rect_out.rect_side     = out_side_q;
	assign rect_out.last_of_glyph = out_last_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgr_pkg::*;

	localparam int COORD_BITS      = COORD_BITS_DEF;
	localparam int COORD_MAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int COORD_MIN       = -COORD_MAX - 1;
	localparam int NO_GLYPH        = -1;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_CHARS     = 26;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 first;
	} char_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [SCALE_BITS-1:0] side;
		logic                  last;
	} rect_cmd_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_ADDR-1:0] paddr;
	logic [APB_DATA-1:0] pwdata;
	logic [APB_DATA-1:0] prdata;
	logic                pready;

	logic tx_idle;
	logic rx_idle;
	logic rx_hold;

	char_item_t char_queue[$];
	rect_cmd_t  rect_expect[$];

	int queued_total = 0;
	int taken_total  = 0;
	int errors       = 0;
	int quiet_cycles = 0;
	int tx_gap       = 0;
	int rx_stall     = 0;

	// Shadow of the block's registers and text cursor.
	int org_x;
	int org_y;
	int dot_side;
	int pen_x;

	sgr_char_if                           char_bus();
	sgr_rect_if #(.COORD_BITS(COORD_BITS)) rect_bus();

	scaled_glyph_rectangle_generator #(.COORD_BITS(COORD_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_bus),
		.rect_out (rect_bus),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Each word holds columns 0..4 from the top byte down; bit 0 of a byte is the top row.
	function automatic logic [39:0] font_bytes(input int g);
		case (g)
			0:       return 40'h3E_51_49_45_3E;
			1:       return 40'h00_42_7F_40_00;
			2:       return 40'h42_61_51_49_46;
			3:       return 40'h21_41_45_4B_31;
			4:       return 40'h18_14_12_7F_10;
			5:       return 40'h27_45_45_45_39;
			6:       return 40'h3C_4A_49_49_30;
			7:       return 40'h01_71_09_05_03;
			8:       return 40'h36_49_49_49_36;
			9:       return 40'h06_49_49_29_1E;
			10:      return 40'h7E_11_11_11_7E;
			11:      return 40'h7F_49_49_49_36;
			12:      return 40'h3E_41_41_41_22;
			13:      return 40'h7F_41_41_22_1C;
			14:      return 40'h7F_49_49_49_41;
			15:      return 40'h7F_09_09_01_01;
			16:      return 40'h3E_41_41_51_32;
			17:      return 40'h7F_08_08_08_7F;
			18:      return 40'h00_41_7F_41_00;
			19:      return 40'h20_40_41_3F_01;
			20:      return 40'h7F_08_14_22_41;
			21:      return 40'h7F_40_40_40_40;
			22:      return 40'h7F_02_04_02_7F;
			23:      return 40'h7F_04_08_10_7F;
			24:      return 40'h3E_41_41_41_3E;
			25:      return 40'h7F_09_09_09_06;
			26:      return 40'h3E_41_51_21_5E;
			27:      return 40'h7F_09_19_29_46;
			28:      return 40'h46_49_49_49_31;
			29:      return 40'h01_01_7F_01_01;
			30:      return 40'h3F_40_40_40_3F;
			31:      return 40'h1F_20_40_20_1F;
			32:      return 40'h7F_20_18_20_7F;
			33:      return 40'h63_14_08_14_63;
			34:      return 40'h03_04_78_04_03;
			35:      return 40'h61_51_49_45_43;
			default: return '0;
		endcase
	endfunction

	function automatic int font_slot(input logic [CODE_BITS-1:0] code);
		logic [CODE_BITS-1:0] up;
		up = code;
		if (code >= CHR_LOWER_A && code <= CHR_LOWER_Z)
			up = code - (CHR_LOWER_A - CHR_UPPER_A);
		if (up >= CHR_DIGIT_0 && up <= CHR_DIGIT_9)
			return int'(up - CHR_DIGIT_0);
		if (up >= CHR_UPPER_A && up <= CHR_UPPER_Z)
			return int'(LETTER_BASE) + int'(up - CHR_UPPER_A);
		return NO_GLYPH;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Queues the squares one character draws and moves the cursor past it.
	task automatic draw_char(input logic [CODE_BITS-1:0] code, input logic first);
		int                   g;
		int                   col;
		int                   row;
		logic [7:0]           column;
		rect_cmd_t            cmd;
		logic                 held;
		if (first)
			pen_x = org_x;
		g    = font_slot(code);
		held = 1'b0;
		cmd  = '0;
		if (g != NO_GLYPH && dot_side != 0) begin
			for (col = 0; col < FONT_COLS; col++) begin
				column = 8'(font_bytes(g) >> (8 * (FONT_COLS - 1 - col)));
				for (row = 0; row < FONT_ROWS; row++) begin
					if (column[row]) begin
						if (held)
							rect_expect.push_back(cmd);
						cmd.x    = COORD_BITS'(clamp_coord(pen_x + col * dot_side));
						cmd.y    = COORD_BITS'(clamp_coord(org_y + row * dot_side));
						cmd.side = SCALE_BITS'(dot_side);
						cmd.last = 1'b0;
						held     = 1'b1;
					end
				end
			end
			if (held) begin
				cmd.last = 1'b1;
				rect_expect.push_back(cmd);
			end
		end
		pen_x = clamp_coord(pen_x + (FONT_COLS + GAP_DOTS_DEF) * dot_side);
	endtask

	task automatic flag_error(input string msg);
		$display("%s", msg);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic push_char(input logic [CODE_BITS-1:0] code, input logic first);
		char_item_t it;
		it.code  = code;
		it.first = first;
		char_queue.push_back(it);
		queued_total++;
	endtask

	// Mostly drawable words that open with first_of_text, with some stray bytes mixed in.
	task automatic queue_random_text(input int n);
		int                   k;
		int                   r;
		int                   word_left;
		logic [CODE_BITS-1:0] c;
		logic                 first;
		word_left = 0;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				c = CHR_UPPER_A + CODE_BITS'($urandom_range(0, 25));
			else if (r < 60)
				c = CHR_LOWER_A + CODE_BITS'($urandom_range(0, 25));
			else if (r < 75)
				c = CHR_DIGIT_0 + CODE_BITS'($urandom_range(0, 9));
			else
				c = CODE_BITS'($urandom_range(0, 255));
			if (word_left == 0) begin
				first     = 1'b1;
				word_left = $urandom_range(1, 8);
			end else begin
				first = ($urandom_range(0, 19) == 0);
			end
			word_left--;
			push_char(c, first);
		end
	endtask

	function automatic logic [APB_DATA-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 3))
			0:       v = $urandom_range(0, 65535);
			1:       v = $urandom_range(0, 400) - 100;
			2:       v = COORD_MAX - int'($urandom_range(0, 400));
			default: v = COORD_MIN + int'($urandom_range(0, 50));
		endcase
		return {16'($urandom), 16'(v)};
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR'(idx) << REG_SEL_LSB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ORIGIN_X:    org_x = int'($signed(value[COORD_BITS-1:0]));
			REG_ORIGIN_Y:    org_y = int'($signed(value[COORD_BITS-1:0]));
			REG_GLYPH_SCALE: dot_side = int'(value[SCALE_BITS-1:0]);
			default:         ;
		endcase
	endtask

	// Waits until every character is taken and every square has arrived, then lets
	// the block finish any trailing blank before registers change.
	task automatic settle();
		while (taken_total != queued_total || rect_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : char_driver
		char_item_t nxt;
		logic       holding;
		if (!arst_n) begin
			char_bus.valid         <= 1'b0;
			char_bus.char_code     <= '0;
			char_bus.first_of_text <= 1'b0;
			tx_gap = 0;
		end else begin
			holding = char_bus.valid;
			if (char_bus.valid && char_bus.ready) begin
				draw_char(char_bus.char_code, char_bus.first_of_text);
				taken_total++;
				holding = 1'b0;
			end
			if (!holding) begin
				if (tx_gap > 0) begin
					tx_gap--;
					char_bus.valid <= 1'b0;
				end else if (char_queue.size() != 0) begin
					nxt = char_queue.pop_front();
					char_bus.char_code     <= nxt.code;
					char_bus.first_of_text <= nxt.first;
					char_bus.valid         <= 1'b1;
					tx_gap = (tx_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
				end else begin
					char_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rect_monitor
		rect_cmd_t want;
		if (!arst_n) begin
			rect_bus.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (rect_bus.valid && rect_bus.ready) begin
				if (rect_expect.size() == 0) begin
					flag_error($sformatf("unexpected square at x=%0h y=%0h",
						rect_bus.rect_x, rect_bus.rect_y));
				end else begin
					want = rect_expect.pop_front();
					if (rect_bus.rect_x !== want.x)
						flag_error($sformatf("rect_x: expected %0h, got %0h",
							want.x, rect_bus.rect_x));
					if (rect_bus.rect_y !== want.y)
						flag_error($sformatf("rect_y: expected %0h, got %0h",
							want.y, rect_bus.rect_y));
					if (rect_bus.rect_side !== want.side)
						flag_error($sformatf("rect_side: expected %0d, got %0d",
							want.side, rect_bus.rect_side));
					if (rect_bus.last_of_glyph !== want.last)
						flag_error($sformatf("last_of_glyph: expected %0b, got %0b",
							want.last, rect_bus.last_of_glyph));
				end
			end
			if (rx_hold) begin
				rect_bus.ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				rect_bus.ready <= 1'b0;
			end else begin
				rect_bus.ready <= 1'b1;
				if (rx_idle && $urandom_range(0, 99) < 12)
					rx_stall = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_bus.valid && char_bus.ready) || (rect_bus.valid && rect_bus.ready)
					|| (psel && penable && pready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int p;
		int s;
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		tx_idle                = 1'b1;
		rx_idle                = 1'b1;
		rx_hold                = 1'b0;
		org_x                  = 0;
		org_y                  = 0;
		dot_side               = 1;
		pen_x                  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: range ends of each character class and the bytes just outside.
		push_char(CHR_DIGIT_0, 1'b1);
		push_char(CHR_DIGIT_9, 1'b0);
		push_char(CHR_UPPER_A, 1'b0);
		push_char(CHR_UPPER_Z, 1'b0);
		push_char(CHR_LOWER_A, 1'b0);
		push_char(CHR_LOWER_Z, 1'b0);
		push_char(CHR_DIGIT_0 - 8'd1, 1'b0);
		push_char(CHR_DIGIT_9 + 8'd1, 1'b0);
		push_char(CHR_UPPER_A - 8'd1, 1'b0);
		push_char(CHR_UPPER_Z + 8'd1, 1'b0);
		push_char(CHR_LOWER_A - 8'd1, 1'b0);
		push_char(CHR_LOWER_Z + 8'd1, 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b0);
		push_char(8'h80, 1'b0);
		push_char(CHR_UPPER_A + 8'd12, 1'b1);
		push_char(CHR_UPPER_A + 8'd22, 1'b0);
		settle();

		// Near the positive corner with the largest dots, so x, y and the cursor saturate.
		reg_write(REG_ORIGIN_X, 32'hA5A5_7FF5);
		reg_write(REG_ORIGIN_Y, 32'hFFFF_7FFA);
		reg_write(REG_GLYPH_SCALE, 32'hFFFF_FFFF);
		push_char(CHR_DIGIT_0 + 8'd8, 1'b1);
		push_char(CHR_UPPER_A + 8'd1, 1'b0);
		push_char(CHR_UPPER_Z + 8'd1, 1'b0);
		settle();

		// Negative corner; a write to an unmapped address must change nothing.
		reg_write(REG_ORIGIN_X, 32'h0000_8000);
		reg_write(REG_ORIGIN_Y, 32'h1234_8000);
		reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		push_char(CHR_UPPER_A + 8'd16, 1'b1);
		push_char(CHR_LOWER_A + 8'd23, 1'b0);
		settle();

		// Zero scale draws nothing, but first_of_text still loads the cursor.
		reg_write(REG_ORIGIN_X, 32'h0000_0064);
		reg_write(REG_ORIGIN_Y, 32'h0000_FFF0);
		reg_write(REG_GLYPH_SCALE, 32'hFFFF_FFC0);
		push_char(CHR_UPPER_A + 8'd10, 1'b1);
		push_char(CHR_DIGIT_0 + 8'd7, 1'b0);
		settle();
		reg_write(REG_GLYPH_SCALE, 32'h0000_0001);
		push_char(CHR_UPPER_A + 8'd7, 1'b0);
		settle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 2)
				s = 63;
			else if (p == 6)
				s = $urandom_range(20, 63);
			else
				s = $urandom_range(1, 3);
			reg_write(REG_ORIGIN_X, pick_coord());
			reg_write(REG_ORIGIN_Y, pick_coord());
			reg_write(REG_GLYPH_SCALE, {26'($urandom), 6'(s)});
			if (p % 4 == 3)
				reg_write(REG_UNMAPPED, $urandom);
			tx_idle <= (p % 3 != 0) && (p != 4);
			rx_idle <= (p % 4 != 1);
			// The receiver holds off while the sender keeps offering, so the block backs up.
			if (p == 4)
				rx_hold <= 1'b1;
			queue_random_text(PHASE_CHARS);
			if (p == 4) begin
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
			settle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
